// File: rtl/pnlt_pkg.sv
// Shared constants, field widths and opcodes of the page number list table.
`default_nettype none
package pnlt_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY) + 1;
  localparam int PAGE_W    = 31;
  localparam int SLOT_W    = 10;
  localparam int OP_W      = 2;
  localparam int OUT_CNT_W = 11;
  localparam int CMP_W     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

endpackage
`default_nettype wire

// File: rtl/pnlt_if.sv
// Valid/ready channel interfaces for requests and results of the list table.
`default_nettype none
interface pnlt_in_if import pnlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PAGE_W-1:0] page_number;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output opcode, output page_number, output slot,
                  input ready);
  modport sink   (input valid, input opcode, input page_number, input slot,
                  output ready);
endinterface

interface pnlt_out_if import pnlt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [PAGE_W-1:0]    read_value;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 is_full;
  logic                 is_empty;
  logic                 merge_recommended;

  modport source (output valid, output ok, output read_value, output entry_count,
                  output is_full, output is_empty, output merge_recommended,
                  input ready);
  modport sink   (input valid, input ok, input read_value, input entry_count,
                  input is_full, input is_empty, input merge_recommended,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/page_number_list_table.sv
// Page number list table: packed unsorted list with search and compacting delete.
//
// Usage:
//   in_ch  (sink)   - one request transaction: opcode, page_number, slot.
//                     Opcode append adds a page number at the tail unless the
//                     count has reached CAPACITY-1; remove deletes the first
//                     matching entry and slides later entries down; read
//                     returns the entry at a slot below the count.
//   out_ch (source) - exactly one result transaction per request, carrying
//                     ok, read_value, and the status flags after the request.
// Timing:
//   Append, read and unused opcodes: the sequencer goes straight to its finish
//   step, which loads the result into the output register once it is free.
//   Remove: one single-port memory with a registered read and one shared
//   equality compare are reused; each entry examined takes a read step and a
//   compare step, and each entry moved down takes a read step and a write step.
//   One request is in flight at a time; in_ch.ready is high only while the
//   sequencer is idle.
// Reset: the fill count and handshakes clear at once; the store contents are
//   left as they are and never read before written, so no clearing pass runs.
// Stall: a result waits in the output register while out_ch.ready is low;
//   the sequencer holds in its finish step until the register frees.
`default_nettype none
module page_number_list_table import pnlt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pnlt_in_if.sink    in_ch,
  pnlt_out_if.source out_ch
);

  // One-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SRCH_RD  = 6'b000010,
    S_SRCH_CMP = 6'b000100,
    S_SH_RD    = 6'b001000,
    S_SH_WR    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic                ok_r, ok_nxt;

  // Store and its single port
  logic [PAGE_W-1:0]   mem [CAPACITY];
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [PAGE_W-1:0]   wr_data;
  logic [PAGE_W-1:0]   rd_data_r;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [PAGE_W-1:0]    out_value_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  logic                 out_full_r, out_empty_r, out_merge_r;
  logic                 out_load;

  logic                 in_fire;
  logic                 page_match;
  logic [CNT_W-1:0]     idx_plus1, idx_plus2;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The shared compare unit used by every search step
  assign page_match = (rd_data_r == page_r);
  assign idx_plus1  = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_plus2  = CNT_W'(idx_r) + CNT_W'(2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    page_nxt  = page_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    out_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_ch.opcode;
          page_nxt  = in_ch.page_number;
          ok_nxt    = 1'b0;
          state_nxt = S_FINISH;
          case (in_ch.opcode)
            OP_APPEND: begin
              // Full leaves one slot unused
              if (count_r < CNT_W'(CAPACITY - 1)) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[ADDR_W-1:0];
                wr_data   = in_ch.page_number;
                count_nxt = count_r + CNT_W'(1);
                ok_nxt    = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_SRCH_RD;
              end
            end
            OP_READ: begin
              if (CMP_W'(in_ch.slot) < CMP_W'(count_r)) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(in_ch.slot);
                ok_nxt  = 1'b1;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (page_match) begin
          if (idx_plus1 < count_r) begin
            state_nxt = S_SH_RD;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
            state_nxt = S_FINISH;
          end
        end else if (idx_plus1 < count_r) begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r + ADDR_W'(1);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // Move the next entry down one slot
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        idx_nxt = idx_r + ADDR_W'(1);
        if (idx_plus2 < count_r) begin
          state_nxt = S_SH_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    op_r   <= op_nxt;
    page_r <= page_nxt;
    ok_r   <= ok_nxt;
    if (out_load) begin
      out_ok_r    <= ok_r;
      out_value_r <= (op_r == OP_READ && ok_r) ? rd_data_r : '0;
      out_count_r <= OUT_CNT_W'(count_r);
      out_full_r  <= (count_r >= CNT_W'(CAPACITY - 1));
      out_empty_r <= (count_r == '0);
      out_merge_r <= (count_r < CNT_W'(CAPACITY / 2));
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.ok                = out_ok_r;
  assign out_ch.read_value        = out_value_r;
  assign out_ch.entry_count       = out_count_r;
  assign out_ch.is_full           = out_full_r;
  assign out_ch.is_empty          = out_empty_r;
  assign out_ch.merge_recommended = out_merge_r;

  // The count never reaches capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY - 1))
    else $error("fill count exceeds capacity - 1");

  // A fitting append grows the count by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_APPEND && count_r < CNT_W'(CAPACITY - 1))
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not advance the count");

  // Search and shift steps stay inside the stored entries
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_RD || state_r == S_SRCH_CMP ||
     state_r == S_SH_RD || state_r == S_SH_WR) |-> CNT_W'(idx_r) < count_r)
    else $error("list walk index beyond fill count");

  // A shift step always has an entry above it to move
  a_shift_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_RD) |-> idx_plus1 < count_r)
    else $error("shift reads past the last entry");

  // A result appears only from the finish step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

endmodule
`default_nettype wire

// File: tb/page_number_list_table_test.sv
// Self-checking testbench for the page number list table: directed table, random traffic.
`default_nettype none
module page_number_list_table_test;
  import pnlt_pkg::*;

  // Opcode value that the block must ignore while still reporting status.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;

  // One result transaction as seen on out_ch.
  typedef struct packed {
    logic                 ok;
    logic [PAGE_W-1:0]    read_value;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
    logic                 merge_recommended;
  } list_status_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    bit                typed;
    list_status_t      want;
  } plan_row_t;

  localparam list_status_t NO_STATUS = '0;

  logic clk = 1'b0;
  logic rst_n;

  pnlt_in_if  in_ch ();
  pnlt_out_if out_ch ();

  page_number_list_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the packed list: index equals slot, size equals fill count.
  logic [PAGE_W-1:0] shadow_pages[$];
  // Results still owed by the block, oldest first.
  list_status_t      pending_status[$];
  plan_row_t         opening_rows[$];

  int fail_cnt      = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the status it must produce.
  function automatic list_status_t table_apply(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                               logic [SLOT_W-1:0] slot);
    list_status_t st;
    int hit;
    int n;
    st  = '0;
    hit = -1;
    case (op)
      OP_APPEND: begin
        // Full means count reached CAPACITY-1; the last slot stays unused.
        if (shadow_pages.size() + 1 < CAPACITY) begin
          shadow_pages.push_back(page);
          st.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Take only the lowest-slot match; later entries close the gap.
        foreach (shadow_pages[i])
          if (hit < 0 && shadow_pages[i] == page) hit = i;
        if (hit >= 0) begin
          shadow_pages.delete(hit);
          st.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (slot < shadow_pages.size()) begin
          st.ok         = 1'b1;
          st.read_value = shadow_pages[slot];
        end
      end
      default: ;
    endcase
    n = shadow_pages.size();
    st.entry_count       = n[OUT_CNT_W-1:0];
    st.is_full           = (n + 1 >= CAPACITY);
    st.is_empty          = (n == 0);
    st.merge_recommended = (n < CAPACITY / 2);
    return st;
  endfunction

  function automatic void plan_row(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                   logic [SLOT_W-1:0] slot, bit typed, list_status_t want);
    plan_row_t r;
    r.op    = op;
    r.page  = page;
    r.slot  = slot;
    r.typed = typed;
    r.want  = want;
    opening_rows.push_back(r);
  endfunction

  // Offer one request transaction; keep valid high on return so back-to-back
  // requests never drop it in between.
  task automatic offer(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                       logic [SLOT_W-1:0] slot, bit typed, list_status_t want);
    list_status_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    // Requests are accepted in order, so predicting at offer time is safe.
    predicted = table_apply(op, page, slot);
    pending_status.push_back(typed ? want : predicted);
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.page_number <= page;
    in_ch.slot        <= slot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly well-formed traffic: removes of stored pages, reads below the count,
  // duplicates on purpose; the rest is misses, reads past the end and unused opcodes.
  task automatic random_transaction();
    int pick;
    int n;
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    n    = shadow_pages.size();
    pick = $urandom_range(0, 99);
    page = PAGE_W'($urandom);
    slot = SLOT_W'($urandom_range(0, 1023));
    if (pick < 5) begin
      op = OP_UNUSED;
    end else if (pick < ((n > 40) ? 30 : 50)) begin
      op = OP_APPEND;
      if (n > 0 && $urandom_range(0, 3) == 0)
        page = shadow_pages[$urandom_range(0, n - 1)];
      else if ($urandom_range(0, 3) == 0)
        page = PAGE_W'($urandom_range(0, 15));
    end else if (pick < 75) begin
      op = OP_REMOVE;
      if (n > 0 && $urandom_range(0, 9) < 7)
        page = shadow_pages[$urandom_range(0, n - 1)];
    end else begin
      op = OP_READ;
      if (n > 0 && $urandom_range(0, 9) < 8)
        slot = SLOT_W'($urandom_range(0, n - 1));
    end
    offer(op, page, slot, 1'b0, NO_STATUS);
  endtask

  task automatic random_run(int count);
    repeat (count) random_transaction();
  endtask

  // Drop valid and hold the sender until every owed result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_failure(string what, list_status_t want, list_status_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display({"%s: exp ok=%0d val=%h cnt=%0d full=%0d empty=%0d merge=%0d",
                " | act ok=%0d val=%h cnt=%0d full=%0d empty=%0d merge=%0d"},
               what, want.ok, want.read_value, want.entry_count, want.is_full,
               want.is_empty, want.merge_recommended, got.ok, got.read_value,
               got.entry_count, got.is_full, got.is_empty, got.merge_recommended);
  endtask

  // Receiver: random stalls per phase, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    list_status_t got;
    list_status_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.ok, out_ch.read_value, out_ch.entry_count, out_ch.is_full,
             out_ch.is_empty, out_ch.merge_recommended};
      if (pending_status.size() == 0) begin
        note_failure("unexpected result", NO_STATUS, got);
      end else begin
        want = pending_status.pop_front();
        if (got !== want) note_failure("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_APPEND;
    in_ch.page_number <= '0;
    in_ch.slot        <= '0;

    // Empty list: every probe fails and reports empty with merge advised.
    plan_row(OP_READ,   31'd0, 10'd0,    1'b1, '{1'b0, 31'd0, 11'd0, 1'b0, 1'b1, 1'b1});
    plan_row(OP_REMOVE, 31'd0, 10'd0,    1'b1, '{1'b0, 31'd0, 11'd0, 1'b0, 1'b1, 1'b1});
    plan_row(OP_UNUSED, 31'd0, 10'd0,    1'b1, '{1'b0, 31'd0, 11'd0, 1'b0, 1'b1, 1'b1});
    plan_row(OP_READ,   31'd0, 10'd1023, 1'b1, '{1'b0, 31'd0, 11'd0, 1'b0, 1'b1, 1'b1});
    // Largest page number goes in and reads back intact.
    plan_row(OP_APPEND, 31'h7FFF_FFFF, 10'd0, 1'b1, '{1'b1, 31'd0, 11'd1, 1'b0, 1'b0, 1'b1});
    plan_row(OP_READ,   31'd0, 10'd0, 1'b1,
             '{1'b1, 31'h7FFF_FFFF, 11'd1, 1'b0, 1'b0, 1'b1});
    // Read at the count itself is past the end.
    plan_row(OP_READ,   31'd0, 10'd1, 1'b1, '{1'b0, 31'd0, 11'd1, 1'b0, 1'b0, 1'b1});
    // Duplicates: a remove must take only the lowest-slot copy.
    plan_row(OP_APPEND, 31'd0,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_APPEND, 31'd5,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_APPEND, 31'd0,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_APPEND, 31'd5,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_REMOVE, 31'd0,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_READ,   31'd0,        10'd1,    1'b0, NO_STATUS);
    plan_row(OP_READ,   31'd0,        10'd2,    1'b0, NO_STATUS);
    plan_row(OP_READ,   31'd0,        10'd3,    1'b0, NO_STATUS);
    // Miss on a populated list, then two removes that each take the head.
    plan_row(OP_REMOVE, 31'd12345,    10'd0,    1'b0, NO_STATUS);
    plan_row(OP_REMOVE, 31'h7FFF_FFFF, 10'd0,   1'b0, NO_STATUS);
    plan_row(OP_REMOVE, 31'd5,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_UNUSED, 31'h7FFF_FFFF, 10'd1023, 1'b0, NO_STATUS);
    plan_row(OP_READ,   31'h7FFF_FFFF, 10'd1023, 1'b0, NO_STATUS);
    // Empty it again, then miss on the empty list.
    plan_row(OP_REMOVE, 31'd0,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_REMOVE, 31'd5,        10'd0,    1'b0, NO_STATUS);
    plan_row(OP_REMOVE, 31'd5,        10'd0,    1'b0, NO_STATUS);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table with no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (opening_rows[i])
      offer(opening_rows[i].op, opening_rows[i].page, opening_rows[i].slot,
            opening_rows[i].typed, opening_rows[i].want);
    random_run(60);
    drain();

    // Sender gaps only.
    send_idle_pct = 47;
    random_run(70);
    drain();

    // Receiver stalls; midway hold it off for a long stretch while the
    // sender keeps offering, so the block backs up into its input.
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    random_run(20);
    hold_req = 1'b1;
    random_run(50);
    drain();

    // Both sides idle.
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    random_run(70);
    drain();

    // Catch any stray result after the last one owed.
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("page_number_list_table test passed");
    else
      $display("page_number_list_table test failed");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #50000000;
    $display("page_number_list_table test failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: page_number_list_table.f
rtl/pnlt_pkg.sv
rtl/pnlt_if.sv
rtl/page_number_list_table.sv
tb/page_number_list_table_test.sv
